/* design/tsle_pkg.sv */
// Shared types and constants of the two-stack line cursor editor.
package tsle_pkg;

	localparam int LINE_CAP_DEF = 256;
	localparam int OP_W         = 3;
	localparam int CH_W         = 8;
	localparam int COUNT_W      = 9;

	typedef enum logic [OP_W-1:0] {
		OP_RIGHT      = 3'd0,
		OP_LEFT       = 3'd1,
		OP_END        = 3'd2,
		OP_START      = 3'd3,
		OP_DEL_AT     = 3'd4,
		OP_DEL_BEFORE = 3'd5,
		OP_INSERT     = 3'd6,
		OP_OVERWRITE  = 3'd7
	} op_e;

	// Per-cell shift enables: take the value from the cell nearer the top,
	// or from the cell farther from it.
	typedef struct packed {
		logic take_shallow;
		logic take_deep;
	} cell_ctl_t;

	// Per-stack command: push a character, pop the top, or rewrite the top.
	typedef struct packed {
		logic push;
		logic pop;
		logic wr_top;
	} stack_ctl_t;

endpackage

/* design/tsle_cmd_if.sv */
// Command channel: valid/ready handshake carrying op and ch.
interface tsle_cmd_if;
	import tsle_pkg::*;

	logic            valid;
	logic            ready;
	logic [OP_W-1:0] op;
	logic [CH_W-1:0] ch;

	modport source (output valid, output op, output ch, input ready);
	modport sink   (input valid, input op, input ch, output ready);
endinterface

/* design/tsle_res_if.sv */
// Result channel: valid/ready handshake carrying counts and neighbor characters.
interface tsle_res_if;
	import tsle_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] left_count;
	logic [COUNT_W-1:0] right_count;
	logic [CH_W-1:0]    char_before;
	logic               before_valid;
	logic [CH_W-1:0]    char_at;
	logic               at_valid;
	logic               full_reject;

	modport source (output valid, output left_count, output right_count,
		output char_before, output before_valid, output char_at, output at_valid,
		output full_reject, input ready);
	modport sink   (input valid, input left_count, input right_count,
		input char_before, input before_valid, input char_at, input at_valid,
		input full_reject, output ready);
endinterface

/* design/tsle_cell.sv */
// One character cell of a stack row; loads from either neighbor.
module tsle_cell #(
	parameter int W = tsle_pkg::CH_W
) (
	input  logic               clk,
	input  tsle_pkg::cell_ctl_t ctl,
	input  logic [W-1:0]       shallow_d,
	input  logic [W-1:0]       deep_d,
	output logic [W-1:0]       q
);
	import tsle_pkg::*;

	logic [W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctl.take_shallow) begin
			val_q <= shallow_d;
		end else if (ctl.take_deep) begin
			val_q <= deep_d;
		end
	end

	assign q = val_q;
endmodule

/* design/tsle_stack.sv */
// Stack built as a row of shifting cells, with its fill count.
module tsle_stack #(
	parameter int DEPTH = tsle_pkg::LINE_CAP_DEF,
	parameter int W = tsle_pkg::CH_W,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsle_pkg::stack_ctl_t ctl,
	input  logic [W-1:0]         din,
	output logic [W-1:0]         top,
	output logic [CNT_W-1:0]     count
);
	import tsle_pkg::*;

	logic [W-1:0]     cell_q [DEPTH];
	logic [CNT_W-1:0] count_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t    cctl;
		logic [W-1:0] shallow;
		logic [W-1:0] deep;

		if (i == 0) begin : g_head
			assign cctl.take_shallow = ctl.push | ctl.wr_top;
			assign shallow = din;
		end else begin : g_body
			assign cctl.take_shallow = ctl.push;
			assign shallow = cell_q[i-1];
		end
		assign cctl.take_deep = ctl.pop;

		if (i == DEPTH - 1) begin : g_tail
			assign deep = cell_q[i];
		end else begin : g_inner
			assign deep = cell_q[i+1];
		end

		tsle_cell #(.W(W)) u_cell (
			.clk       (clk),
			.ctl       (cctl),
			.shallow_d (shallow),
			.deep_d    (deep),
			.q         (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push && !ctl.pop) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.pop && !ctl.push) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign top   = cell_q[0];
	assign count = count_q;
endmodule

/* design/two_stack_line_cursor_editor.sv */
// Line editor with a cursor, kept as two stacks of shifting character cells.
// A step, delete, insert or overwrite request is applied at the edge that accepts it;
// its result is then registered onto res from the response state once the previous
// result has been taken. A jump moves one character per cycle between the stacks until
// the source stack is empty, then passes through the response state the same way.
// The next request is taken only once the sequencer is back in the idle state.
// Reset clears both counts, the sequencer and the result valid flag; cells are not reset.
module two_stack_line_cursor_editor #(
	parameter int LINE_CAP = tsle_pkg::LINE_CAP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tsle_cmd_if.sink   cmd,
	tsle_res_if.source res
);
	import tsle_pkg::*;

	localparam int CNT_W = $clog2(LINE_CAP + 1);

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_JUMP = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t state_q;
	logic   jump_right_q;
	logic   reject_q;

	// The left stack holds the characters before the cursor with the nearest one
	// on top; the right stack holds the characters from the cursor onward, the
	// character at the cursor on top.
	stack_ctl_t       lctl, rctl;
	logic [CH_W-1:0]  ldin, rdin, ltop, rtop;
	logic [CNT_W-1:0] lcount, rcount;
	logic [CNT_W:0]   total;
	logic             full;

	// Result register.
	logic               out_valid_q;
	logic [COUNT_W-1:0] left_count_q, right_count_q;
	logic [CH_W-1:0]    char_before_q, char_at_q;
	logic               before_valid_q, at_valid_q, full_reject_q;

	logic cmd_acc;
	logic move_right, move_left;
	logic out_load;
	op_e  op;

	tsle_stack #(.DEPTH(LINE_CAP), .W(CH_W)) u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lctl),
		.din    (ldin),
		.top    (ltop),
		.count  (lcount)
	);

	tsle_stack #(.DEPTH(LINE_CAP), .W(CH_W)) u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.din    (rdin),
		.top    (rtop),
		.count  (rcount)
	);

	assign op      = op_e'(cmd.op);
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc = cmd.valid && cmd.ready;
	assign total   = {1'b0, lcount} + {1'b0, rcount};
	assign full    = (total >= (CNT_W+1)'(LINE_CAP));

	// A cursor step moves the top character from one stack to the other. Jumps
	// repeat that step once per cycle until the source stack is empty.
	always_comb begin
		move_right = 1'b0;
		move_left  = 1'b0;
		lctl       = '0;
		rctl       = '0;
		if (cmd_acc) begin
			case (op)
				OP_RIGHT:      move_right = (rcount != '0);
				OP_LEFT:       move_left  = (lcount != '0);
				OP_DEL_AT:     rctl.pop   = (rcount != '0);
				OP_DEL_BEFORE: lctl.pop   = (lcount != '0);
				OP_INSERT:     lctl.push  = !full;
				OP_OVERWRITE:  rctl.wr_top = (rcount != '0);
				default: ;
			endcase
		end else if (state_q == ST_JUMP) begin
			move_right = jump_right_q && (rcount != '0);
			move_left  = !jump_right_q && (lcount != '0);
		end
		if (move_right) begin
			rctl.pop  = 1'b1;
			lctl.push = 1'b1;
		end
		if (move_left) begin
			lctl.pop  = 1'b1;
			rctl.push = 1'b1;
		end
	end

	assign ldin = move_right ? rtop : cmd.ch;
	assign rdin = move_left ? ltop : cmd.ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			jump_right_q <= 1'b0;
			reject_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						reject_q     <= (op == OP_INSERT) && full;
						jump_right_q <= (op == OP_END);
						if (op == OP_END || op == OP_START) begin
							state_q <= ST_JUMP;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_JUMP: begin
					// The last character crosses in this cycle, or none is left.
					if (jump_right_q ? (rcount <= CNT_W'(1)) : (lcount <= CNT_W'(1))) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The stacks have settled by the time the sequencer reaches the response
	// state; the result is captured once the previous one has been taken.
	assign out_load = (state_q == ST_RESP) && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_count_q   <= COUNT_W'(lcount);
			right_count_q  <= COUNT_W'(rcount);
			before_valid_q <= (lcount != '0);
			char_before_q  <= (lcount != '0) ? ltop : '0;
			at_valid_q     <= (rcount != '0);
			char_at_q      <= (rcount != '0) ? rtop : '0;
			full_reject_q  <= reject_q;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.left_count   = left_count_q;
	assign res.right_count  = right_count_q;
	assign res.char_before  = char_before_q;
	assign res.before_valid = before_valid_q;
	assign res.char_at      = char_at_q;
	assign res.at_valid     = at_valid_q;
	assign res.full_reject  = full_reject_q;

	// The two stacks together never hold more than a full line.
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total <= (CNT_W+1)'(LINE_CAP))
		else $error("line length exceeds capacity");

	// An insert into a line with room grows the left side by exactly one.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && op == OP_INSERT && !full |=> lcount == $past(lcount) + CNT_W'(1))
		else $error("insert did not grow the left side");

	// A jump only moves characters; the line length stays the same.
	a_jump_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_JUMP |=> total == $past(total))
		else $error("jump changed the line length");

	// A pending response waits while the result register is still occupied.
	a_resp_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESP && out_valid_q && !res.ready |=> state_q == ST_RESP)
		else $error("response dropped while result register was full");
endmodule
